// File: rtl/svpwm_pkg.sv
// Shared types, fixed-point constants and the CORDIC arctangent table of the SVPWM generator.
package svpwm_pkg;

   typedef logic signed [15:0] volt_type;
   typedef logic signed [15:0] depth_type;
   typedef logic signed [32:0] trig_type;
   typedef logic        [2:0]  sector_idx_type;
   typedef logic        [10:0] duty_type;

   localparam int CORDIC_STEPS = 16;

   // Modulation depth limit, 0.577 in Q1.15
   localparam logic [15:0] DEPTH_MAX = 16'd18907;
   // Quarter turn in 2^-24 turn
   localparam logic signed [24:0] QUARTER_T24 = 25'sd4194304;
   // Quarter turn in 2^-16 turn
   localparam logic [15:0] QUARTER_T16 = 16'h4000;
   // Inverse CORDIC gain, Q2.30
   localparam logic signed [32:0] KINV_Q30 = 33'sd652032875;
   // sqrt(3), Q2.30
   localparam logic signed [31:0] SQRT3_Q30 = 32'sd1859775394;
   // One, Q2.30
   localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;
   // ceil(2^25 / 3): exact division by three for values below 2^25
   localparam logic [23:0] RECIP3_Q25 = 24'd11184811;

   // Arctangent of 2^-i in 2^-24 turn
   localparam logic [21:0] ATAN_T24 [CORDIC_STEPS] = '{
      22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
      22'd166669,  22'd83416,   22'd41718,  22'd20860,
      22'd10430,   22'd5215,    22'd2608,   22'd1304,
      22'd652,     22'd326,     22'd163,    22'd81
   };

endpackage

// File: rtl/svpwm_if.sv
// Valid/ready channel interfaces for the voltage command and the duty result.
interface svpwm_req_if import svpwm_pkg::*; ();
   logic       valid;
   logic       ready;
   volt_type   volt_q;
   volt_type   volt_d;
   logic [15:0] elec_angle;

   modport source (output valid, output volt_q, output volt_d, output elec_angle, input ready);
   modport sink   (input valid, input volt_q, input volt_d, input elec_angle, output ready);
endinterface

interface svpwm_rsp_if import svpwm_pkg::*; ();
   logic       valid;
   logic       ready;
   duty_type   duty_a;
   duty_type   duty_b;
   duty_type   duty_c;
   logic [2:0] sector_no;

   modport source (output valid, output duty_a, output duty_b, output duty_c,
                   output sector_no, input ready);
   modport sink   (input valid, input duty_a, input duty_b, input duty_c,
                   input sector_no, output ready);
endinterface

// File: rtl/svpwm_depth.sv
// Modulation depth pipeline: squares, bit-pair square root, restoring divide, clamp (35 stages).
module svpwm_depth import svpwm_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [15:0] supply,
   input  volt_type    volt_q,
   input  volt_type    volt_d,
   output depth_type   depth
);

   localparam int SQ_STAGES  = 16;
   localparam int DIV_STAGES = 15;

   // Stage 0: squares and the q-only path operands
   logic signed [31:0] sq_q_in, sq_d_in;
   logic        [31:0] sq_q_ff, sq_d_ff;
   logic        [15:0] q_raw, abs_q_in, abs_q0_ff;
   logic               dnz0_ff, neg0_ff;

   assign sq_q_in  = volt_q * volt_q;
   assign sq_d_in  = volt_d * volt_d;
   assign q_raw    = volt_q;
   assign abs_q_in = q_raw[15] ? (~q_raw + 16'd1) : q_raw;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_q_ff   <= sq_q_in;
         sq_d_ff   <= sq_d_in;
         abs_q0_ff <= abs_q_in;
         dnz0_ff   <= (volt_d != '0);
         neg0_ff   <= (volt_d == '0) && q_raw[15];
      end
   end

   // Square root pipeline, index 0 holds the sum of squares
   logic [31:0] sn_ff   [SQ_STAGES+1];
   logic [31:0] sr_ff   [SQ_STAGES+1];
   logic [15:0] sabs_ff [SQ_STAGES+1];
   logic        sdnz_ff [SQ_STAGES+1];
   logic        sneg_ff [SQ_STAGES+1];

   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff[0]   <= sq_q_ff + sq_d_ff;
         sr_ff[0]   <= '0;
         sabs_ff[0] <= abs_q0_ff;
         sdnz_ff[0] <= dnz0_ff;
         sneg_ff[0] <= neg0_ff;
      end
   end

   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
      localparam logic [31:0] BIT = 32'd1 << (30 - 2 * g);
      logic [32:0] cand;
      logic        take;

      assign cand = {1'b0, sr_ff[g]} + {1'b0, BIT};
      assign take = {1'b0, sn_ff[g]} >= cand;

      // Try one root bit
      always_ff @(posedge clock) begin
         if (en) begin
            sn_ff[g+1]   <= take ? (sn_ff[g] - cand[31:0]) : sn_ff[g];
            sr_ff[g+1]   <= take ? ((sr_ff[g] >> 1) + BIT) : (sr_ff[g] >> 1);
            sabs_ff[g+1] <= sabs_ff[g];
            sdnz_ff[g+1] <= sdnz_ff[g];
            sneg_ff[g+1] <= sneg_ff[g];
         end
      end
   end

   // Divider setup: a quotient of 2^15 or more is past the clamp
   logic [15:0] sup1;
   logic [15:0] mag_in;

   assign sup1   = (supply == '0) ? 16'd1 : supply;
   assign mag_in = sdnz_ff[SQ_STAGES] ? sr_ff[SQ_STAGES][15:0] : sabs_ff[SQ_STAGES];

   logic [15:0] drem_ff [DIV_STAGES+1];
   logic [14:0] dquo_ff [DIV_STAGES+1];
   logic        dovf_ff [DIV_STAGES+1];
   logic        dneg_ff [DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (en) begin
         drem_ff[0] <= mag_in;
         dquo_ff[0] <= '0;
         dovf_ff[0] <= (mag_in >= sup1);
         dneg_ff[0] <= sneg_ff[SQ_STAGES];
      end
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      logic [16:0] rem2;
      logic        ge;

      assign rem2 = {drem_ff[g], 1'b0};
      assign ge   = rem2 >= {1'b0, sup1};

      // One quotient bit
      always_ff @(posedge clock) begin
         if (en) begin
            drem_ff[g+1] <= ge ? 16'(rem2 - {1'b0, sup1}) : rem2[15:0];
            dquo_ff[g+1] <= {dquo_ff[g][13:0], ge};
            dovf_ff[g+1] <= dovf_ff[g];
            dneg_ff[g+1] <= dneg_ff[g];
         end
      end
   end

   // Clamp and restore the sign
   logic [15:0] quo_ext, mag_clamp;
   depth_type   depth_in, depth_ff;

   assign quo_ext   = {1'b0, dquo_ff[DIV_STAGES]};
   assign mag_clamp = (dovf_ff[DIV_STAGES] || (quo_ext > DEPTH_MAX)) ? DEPTH_MAX : quo_ext;
   assign depth_in  = dneg_ff[DIV_STAGES] ? -$signed(mag_clamp) : $signed(mag_clamp);

   always_ff @(posedge clock) begin
      if (en) begin
         depth_ff <= depth_in;
      end
   end

   assign depth = depth_ff;

endmodule

// File: rtl/svpwm_angle.sv
// Angle pipeline: vectoring CORDIC, sector split, divide by three, rotation CORDIC (35 stages).
module svpwm_angle import svpwm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           valid_in,
   input  volt_type       volt_q,
   input  volt_type       volt_d,
   input  logic [15:0]    elec_angle,
   output logic           valid_out,
   output sector_idx_type sector_idx,
   output trig_type       cos_out,
   output trig_type       sin_out
);

   localparam int LAT = 2 * CORDIC_STEPS + 3;

   // Valid bits travel with the items
   logic valid_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT; j++) begin
            valid_ff[j] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= valid_in;
         for (int j = 1; j < LAT; j++) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end
   end

   // Vectoring: scale by 256, fold the left half plane
   logic signed [27:0] vx_ff   [CORDIC_STEPS+1];
   logic signed [27:0] vy_ff   [CORDIC_STEPS+1];
   logic signed [24:0] vacc_ff [CORDIC_STEPS+1];
   logic        [15:0] vang_ff [CORDIC_STEPS+1];
   logic               vdnz_ff [CORDIC_STEPS+1];

   logic signed [27:0] x_sc, y_sc, x0_in, y0_in;
   logic signed [24:0] acc0_in;

   assign x_sc = {{4{volt_d[15]}}, volt_d, 8'h00};
   assign y_sc = {{4{volt_q[15]}}, volt_q, 8'h00};

   always_comb begin
      x0_in   = x_sc;
      y0_in   = y_sc;
      acc0_in = '0;
      if (x_sc < 0) begin
         if (y_sc >= 0) begin
            x0_in   = y_sc;
            y0_in   = -x_sc;
            acc0_in = QUARTER_T24;
         end else begin
            x0_in   = -y_sc;
            y0_in   = x_sc;
            acc0_in = -QUARTER_T24;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff[0]   <= x0_in;
         vy_ff[0]   <= y0_in;
         vacc_ff[0] <= acc0_in;
         vang_ff[0] <= elec_angle;
         vdnz_ff[0] <= (volt_d != '0);
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      logic signed [27:0] xs, ys;
      logic signed [24:0] at;

      assign xs = vx_ff[i] >>> i;
      assign ys = vy_ff[i] >>> i;
      assign at = $signed({3'b000, ATAN_T24[i]});

      // Drive y towards zero
      always_ff @(posedge clock) begin
         if (en) begin
            if (vy_ff[i] > 0) begin
               vx_ff[i+1]   <= vx_ff[i] + ys;
               vy_ff[i+1]   <= vy_ff[i] - xs;
               vacc_ff[i+1] <= vacc_ff[i] + at;
            end else begin
               vx_ff[i+1]   <= vx_ff[i] - ys;
               vy_ff[i+1]   <= vy_ff[i] + xs;
               vacc_ff[i+1] <= vacc_ff[i] - at;
            end
            vang_ff[i+1] <= vang_ff[i];
            vdnz_ff[i+1] <= vdnz_ff[i];
         end
      end
   end

   // Advance the angle, split into sector and position inside it
   logic        [24:0] acc_rnd;
   logic        [15:0] offset, theta;
   logic        [18:0] theta6;
   logic        [22:0] xz_in, xz_ff;
   sector_idx_type     k17_ff, k18_ff;
   logic        [46:0] prod_in, prod_ff;

   assign acc_rnd = vacc_ff[CORDIC_STEPS] + 25'sd128;
   assign offset  = vdnz_ff[CORDIC_STEPS] ? acc_rnd[23:8] : QUARTER_T16;
   assign theta   = vang_ff[CORDIC_STEPS] + offset;
   assign theta6  = {1'b0, theta, 2'b00} + {2'b00, theta, 1'b0};
   assign xz_in   = {theta6[15:0], 7'd0} + 23'd1;

   always_ff @(posedge clock) begin
      if (en) begin
         k17_ff <= theta6[18:16];
         xz_ff  <= xz_in;
      end
   end

   // Divide by three through the reciprocal
   assign prod_in = {24'd0, xz_ff} * {23'd0, RECIP3_Q25};

   always_ff @(posedge clock) begin
      if (en) begin
         k18_ff  <= k17_ff;
         prod_ff <= prod_in;
      end
   end

   // Rotation: start vector on the x axis at the inverse gain
   trig_type           rx [CORDIC_STEPS+1];
   trig_type           ry [CORDIC_STEPS+1];
   logic signed [24:0] rz [CORDIC_STEPS+1];
   sector_idx_type     rk [CORDIC_STEPS+1];

   assign rx[0] = KINV_Q30;
   assign ry[0] = '0;
   assign rz[0] = $signed({3'b000, prod_ff[46:25]});
   assign rk[0] = k18_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      trig_type           xs, ys;
      logic signed [24:0] at;

      assign xs = rx[i] >>> i;
      assign ys = ry[i] >>> i;
      assign at = $signed({3'b000, ATAN_T24[i]});

      // Drive z towards zero
      always_ff @(posedge clock) begin
         if (en) begin
            if (rz[i] >= 0) begin
               rx[i+1] <= rx[i] - ys;
               ry[i+1] <= ry[i] + xs;
               rz[i+1] <= rz[i] - at;
            end else begin
               rx[i+1] <= rx[i] + ys;
               ry[i+1] <= ry[i] - xs;
               rz[i+1] <= rz[i] + at;
            end
            rk[i+1] <= rk[i];
         end
      end
   end

   assign valid_out  = valid_ff[LAT-1];
   assign sector_idx = rk[CORDIC_STEPS];
   assign cos_out    = rx[CORDIC_STEPS];
   assign sin_out    = ry[CORDIC_STEPS];

endmodule

// File: rtl/svpwm_times.sv
// Switching times, sector duty pattern and saturation to the PWM period (8 stages, last is output).
module svpwm_times import svpwm_pkg::*; #(
   parameter int CARRIER_PERIOD = 1280
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           valid_in,
   input  sector_idx_type sector_idx,
   input  trig_type       cos_in,
   input  trig_type       sin_in,
   input  depth_type      depth,
   output logic           valid_out,
   output duty_type       duty_a,
   output duty_type       duty_b,
   output duty_type       duty_c,
   output logic [2:0]     sector_no
);

   localparam int NV = 7;
   localparam logic signed [17:0] PER_18 = 18'(CARRIER_PERIOD);
   localparam logic signed [23:0] PER_24 = 24'(CARRIER_PERIOD);

   logic valid_ff [NV];
   logic out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NV; j++) begin
            valid_ff[j] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= valid_in;
         for (int j = 1; j < NV; j++) begin
            valid_ff[j] <= valid_ff[j-1];
         end
         out_valid_ff <= valid_ff[NV-1];
      end
   end

   // Stage 0: sqrt3 * cos and sqrt3 * sin
   logic signed [64:0] p1_in, p2_in, p1_ff, p2_ff;
   trig_type           s0_ff;
   depth_type          d0_ff, d1_ff, d2_ff, d3_ff;
   sector_idx_type     k0_ff, k1_ff, k2_ff, k3_ff, k4_ff, k5_ff, k6_ff;

   assign p1_in = SQRT3_Q30 * cos_in;
   assign p2_in = SQRT3_Q30 * sin_in;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         s0_ff <= sin_in;
         d0_ff <= depth;
         k0_ff <= sector_idx;
      end
   end

   // Stage 1: sin(60 deg - phi) = sqrt3/2 cos - 1/2 sin
   trig_type sina_ff, u2a_ff, u2b_ff, u2c_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sina_ff <= 33'(p1_ff >>> 31) - (s0_ff >>> 1);
         u2a_ff  <= 33'(p2_ff >>> 30);
         d1_ff   <= d0_ff;
         k1_ff   <= k0_ff;
      end
   end

   // Stage 2: sqrt3 * sin(60 deg - phi)
   logic signed [64:0] p3_in, p3_ff;

   assign p3_in = SQRT3_Q30 * sina_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p3_ff  <= p3_in;
         u2b_ff <= u2a_ff;
         d2_ff  <= d1_ff;
         k2_ff  <= k1_ff;
      end
   end

   // Stage 3: scale back to Q2.30
   trig_type u1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         u1_ff  <= 33'(p3_ff >>> 30);
         u2c_ff <= u2b_ff;
         d3_ff  <= d2_ff;
         k3_ff  <= k2_ff;
      end
   end

   // Stage 4: times the depth
   logic signed [48:0] m1_in, m2_in, m1_ff, m2_ff;

   assign m1_in = u1_ff * d3_ff;
   assign m2_in = u2c_ff * d3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         k4_ff <= k3_ff;
      end
   end

   // Stage 5: T1, T2, half of T0 and the seven-segment pattern
   logic signed [35:0] t1, t2, t0, half, ta_in, tb_in, tc_in, ta_ff, tb_ff, tc_ff;

   assign t1   = 36'(m1_ff >>> 15);
   assign t2   = 36'(m2_ff >>> 15);
   assign t0   = ONE_Q30 - t1 - t2;
   assign half = t0 >>> 1;

   always_comb begin
      case (k4_ff)
         3'd0: begin
            ta_in = t1 + t2 + half; tb_in = t2 + half;      tc_in = half;
         end
         3'd1: begin
            ta_in = t1 + half;      tb_in = t1 + t2 + half; tc_in = half;
         end
         3'd2: begin
            ta_in = half;           tb_in = t1 + t2 + half; tc_in = t2 + half;
         end
         3'd3: begin
            ta_in = half;           tb_in = t1 + half;      tc_in = t1 + t2 + half;
         end
         3'd4: begin
            ta_in = t2 + half;      tb_in = half;           tc_in = t1 + t2 + half;
         end
         default: begin
            ta_in = t1 + t2 + half; tb_in = half;           tc_in = t1 + half;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ta_ff <= ta_in;
         tb_ff <= tb_in;
         tc_ff <= tc_in;
         k5_ff <= k4_ff;
      end
   end

   // Stage 6: times the period
   logic signed [53:0] pa_in, pb_in, pc_in, pa_ff, pb_ff, pc_ff;

   assign pa_in = ta_ff * PER_18;
   assign pb_in = tb_ff * PER_18;
   assign pc_in = tc_ff * PER_18;

   always_ff @(posedge clock) begin
      if (en) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         pc_ff <= pc_in;
         k6_ff <= k5_ff;
      end
   end

   // Stage 7: saturate into the output register
   function automatic duty_type sat_duty(input logic signed [53:0] p);
      logic signed [23:0] v;
      logic signed [23:0] c;
      v = 24'(p >>> 30);
      if (v < 0) begin
         c = '0;
      end else if (v > PER_24) begin
         c = PER_24;
      end else begin
         c = v;
      end
      return c[10:0];
   endfunction

   duty_type   duty_a_ff, duty_b_ff, duty_c_ff;
   logic [2:0] sector_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         duty_a_ff <= sat_duty(pa_ff);
         duty_b_ff <= sat_duty(pb_ff);
         duty_c_ff <= sat_duty(pc_ff);
         sector_ff <= k6_ff + 3'd1;
      end
   end

   assign valid_out = out_valid_ff;
   assign duty_a    = duty_a_ff;
   assign duty_b    = duty_b_ff;
   assign duty_c    = duty_c_ff;
   assign sector_no = sector_ff;

endmodule

// File: rtl/svpwm_duty_generator_top.sv
// Top level of the space vector PWM duty generator.
// One voltage command (q, d in 1/256 V, electrical angle in 2^-16 turn) is taken every
// clock cycle while the output is not stalled and gives one set of phase compare values
// and the sector. The depth path (square root and divide, one bit per stage) and the angle
// path (two 16-step CORDICs, one step per stage) run side by side for 35 stages, then 8
// stages form the switching times and the output register. The whole pipeline holds while
// a result waits in the output register; nothing is lost or repeated. The user writes the
// supply register through csr_we/csr_wdata only while no item is in flight; the block
// itself does not enforce this. A supply of zero acts as one unit.
module svpwm_duty_generator_top import svpwm_pkg::*; #(
   parameter int CARRIER_PERIOD = 1280
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   svpwm_req_if.sink         req_chan,
   svpwm_rsp_if.source       rsp_chan
);

   // Supply voltage register
   logic [15:0] csr_supply_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_supply_ff <= 16'd3072;
      end else if (csr_we) begin
         csr_supply_ff <= csr_wdata;
      end
   end

   // Advance the whole pipeline unless a result is held
   logic advance;
   logic rsp_valid;

   assign advance        = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   depth_type      depth;
   logic           ang_valid;
   sector_idx_type sector_idx;
   trig_type       cos_w, sin_w;

   svpwm_depth u_depth (
      .clock  (clock),
      .en     (advance),
      .supply (csr_supply_ff),
      .volt_q (req_chan.volt_q),
      .volt_d (req_chan.volt_d),
      .depth  (depth)
   );

   svpwm_angle u_angle (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .valid_in   (req_chan.valid),
      .volt_q     (req_chan.volt_q),
      .volt_d     (req_chan.volt_d),
      .elec_angle (req_chan.elec_angle),
      .valid_out  (ang_valid),
      .sector_idx (sector_idx),
      .cos_out    (cos_w),
      .sin_out    (sin_w)
   );

   svpwm_times #(.CARRIER_PERIOD(CARRIER_PERIOD)) u_times (
      .clock      (clock),
      .reset      (reset),
      .en         (advance),
      .valid_in   (ang_valid),
      .sector_idx (sector_idx),
      .cos_in     (cos_w),
      .sin_in     (sin_w),
      .depth      (depth),
      .valid_out  (rsp_valid),
      .duty_a     (rsp_chan.duty_a),
      .duty_b     (rsp_chan.duty_b),
      .duty_c     (rsp_chan.duty_c),
      .sector_no  (rsp_chan.sector_no)
   );

   assign rsp_chan.valid = rsp_valid;

endmodule

// File: rtl/svpwm_checker.sv
// Port-level assertions for the SVPWM duty generator and their bind to the top level.
module svpwm_checker #(
   parameter int CARRIER_PERIOD = 1280
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] duty_a,
   input logic [10:0] duty_b,
   input logic [10:0] duty_c,
   input logic [2:0]  sector_no
);

   // No result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   // Intake stalls only behind a held result
   a_intake: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("intake ready does not follow output stall");

   // Held result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(duty_a) && $stable(duty_b)
         && $stable(duty_c) && $stable(sector_no))
      else $error("held result changed");

   // Sector and duties in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (sector_no >= 3'd1) && (sector_no <= 3'd6)
         && ((CARRIER_PERIOD > 2047) || ((duty_a <= 11'(CARRIER_PERIOD))
         && (duty_b <= 11'(CARRIER_PERIOD)) && (duty_c <= 11'(CARRIER_PERIOD)))))
      else $error("result out of range");

endmodule

bind svpwm_duty_generator_top svpwm_checker #(.CARRIER_PERIOD(CARRIER_PERIOD)) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .duty_a    (rsp_chan.duty_a),
   .duty_b    (rsp_chan.duty_b),
   .duty_c    (rsp_chan.duty_c),
   .sector_no (rsp_chan.sector_no)
);
